@@ sv/clsr_pkg.sv @@
// ----------------------------------------------------------------------------
// clsr_pkg
// Constants, state codes and helpers for the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
package clsr_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int WARM_STEPS  = TABLE_DEPTH + 8;
  localparam int CNT_W       = $clog2(WARM_STEPS);

  localparam int VAL_W  = 31;
  localparam int MUL_W  = 16;
  localparam int PROD_W = VAL_W + MUL_W;
  localparam int FOLD_W = 8;

  localparam logic [VAL_W-1:0]  MOD_A       = 31'd2147483563;
  localparam logic [VAL_W-1:0]  MOD_B       = 31'd2147483399;
  localparam logic [MUL_W-1:0]  MUL_A       = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL_B       = 16'd40692;
  localparam logic [FOLD_W-1:0] FOLD_A      = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD_B      = 8'd249;
  localparam logic [VAL_W-1:0]  SECOND_SEED = 31'd123456789;
  localparam logic [VAL_W-1:0]  TOP_VALUE   = 31'd2147483562;

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_SEED = 1'b1;

  localparam longint SLOT_DIV = 64'd1 + 64'd2147483562 / TABLE_DEPTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_W_MUL,
    ST_W_RED,
    ST_A_MUL,
    ST_A_RED,
    ST_B_MUL,
    ST_B_RED,
    ST_OUT
  } state_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [VAL_W-1:0] v);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if (longint'(v) >= longint'(k) * SLOT_DIV) begin
        s = SLOT_W'(k);
      end
    end
    return s;
  endfunction

endpackage

@@ sv/combined_lcg_shuffle_rng_unit.sv @@
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_unit
// Two multiplicative congruential generators combined through a shuffle table.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser[0] is the request kind, 0 draws the next
//   deviate, 1 reseeds from tdata[30:0] (zero taken as one), warms up and
//   then draws. Output stream (m_axis): tdata[30:0] carries one deviate in
//   1..2147483562 per request; the uniform value is deviate / 2147483563.
//   One multiplier and one fold-and-subtract reducer are shared by both
//   generators; each modular step has a multiply state and a reduce state.
//   A draw steps the main generator, then the second, then combines them
//   in the output step. A reseed first runs 40 warm-up steps of the main
//   generator, the last 32 of which fill the shuffle table.
//   s_axis_tready is high only while no request is in work.
//   The output register holds a result until taken; the next request may
//   be accepted meanwhile, and its finish step waits while the previous
//   result is still unread.
//   Reset: main state 1, second state 123456789, shuffle table all zero,
//   slot 0, no result pending.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] seed, [31] zero
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [30:0] deviate, [31] zero
);

  clsr_pkg::state_t state;
  clsr_pkg::state_t state_next;

  logic [clsr_pkg::VAL_W-1:0]  main_state;
  logic [clsr_pkg::VAL_W-1:0]  second_state;
  logic [clsr_pkg::SLOT_W-1:0] slot;
  logic [clsr_pkg::CNT_W-1:0]  cnt;
  logic [clsr_pkg::VAL_W-1:0]  shuffle_table [clsr_pkg::TABLE_DEPTH];
  logic [clsr_pkg::PROD_W-1:0] prod;

  logic                         in_fire;
  logic                         out_free;
  logic [clsr_pkg::VAL_W-1:0]   mul_op;
  logic [clsr_pkg::MUL_W-1:0]   mul_k;
  logic [clsr_pkg::VAL_W-1:0]   red_mod;
  logic [clsr_pkg::FOLD_W-1:0]  red_fold;
  logic [clsr_pkg::VAL_W:0]     red_sum;
  logic [clsr_pkg::VAL_W-1:0]   red;
  logic [clsr_pkg::VAL_W-1:0]   seed_v;
  logic [clsr_pkg::VAL_W:0]     diff;
  logic [clsr_pkg::VAL_W:0]     diff_adj;
  logic [clsr_pkg::VAL_W-1:0]   y;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign seed_v   = (s_axis_tdata[30:0] == '0) ? 31'd1 : s_axis_tdata[30:0];

  // shared multiplier operand select
  always_comb begin
    mul_op = main_state;
    mul_k  = clsr_pkg::MUL_A;
    if (state == clsr_pkg::ST_B_MUL) begin
      mul_op = second_state;
      mul_k  = clsr_pkg::MUL_B;
    end
  end

  // shared reducer: fold the bits above 2^31, then one conditional subtract
  always_comb begin
    red_mod  = clsr_pkg::MOD_A;
    red_fold = clsr_pkg::FOLD_A;
    if (state == clsr_pkg::ST_B_RED) begin
      red_mod  = clsr_pkg::MOD_B;
      red_fold = clsr_pkg::FOLD_B;
    end
    red_sum = {1'b0, prod[clsr_pkg::VAL_W-1:0]}
            + 32'(prod[clsr_pkg::PROD_W-1:clsr_pkg::VAL_W] * red_fold);
    if (red_sum >= {1'b0, red_mod}) begin
      red = 31'(red_sum - {1'b0, red_mod});
    end else begin
      red = red_sum[clsr_pkg::VAL_W-1:0];
    end
  end

  // combine with the shuffled entry
  always_comb begin
    diff     = {1'b0, shuffle_table[slot]} - {1'b0, second_state};
    diff_adj = diff + {1'b0, clsr_pkg::TOP_VALUE};
    if (diff[clsr_pkg::VAL_W] || diff == '0) begin
      y = diff_adj[clsr_pkg::VAL_W-1:0];
    end else begin
      y = diff[clsr_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    unique case (state)
      clsr_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser[0] == clsr_pkg::REQ_SEED) ? clsr_pkg::ST_W_MUL
                                                              : clsr_pkg::ST_A_MUL;
        end
      end
      clsr_pkg::ST_W_MUL: state_next = clsr_pkg::ST_W_RED;
      clsr_pkg::ST_W_RED: begin
        state_next = (cnt == '0) ? clsr_pkg::ST_A_MUL : clsr_pkg::ST_W_MUL;
      end
      clsr_pkg::ST_A_MUL: state_next = clsr_pkg::ST_A_RED;
      clsr_pkg::ST_A_RED: state_next = clsr_pkg::ST_B_MUL;
      clsr_pkg::ST_B_MUL: state_next = clsr_pkg::ST_B_RED;
      clsr_pkg::ST_B_RED: state_next = clsr_pkg::ST_OUT;
      clsr_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = clsr_pkg::ST_IDLE;
        end
      end
      default: state_next = clsr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_op * mul_k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_state    <= 31'd1;
      second_state  <= clsr_pkg::SECOND_SEED;
      slot          <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      for (int i = 0; i < clsr_pkg::TABLE_DEPTH; i++) begin
        shuffle_table[clsr_pkg::SLOT_W'(i)] <= '0;
      end
    end else begin
      if (state == clsr_pkg::ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        clsr_pkg::ST_IDLE: begin
          if (in_fire && (s_axis_tuser[0] == clsr_pkg::REQ_SEED)) begin
            main_state   <= seed_v;
            second_state <= seed_v;
            cnt          <= clsr_pkg::CNT_W'(clsr_pkg::WARM_STEPS - 1);
          end
        end
        clsr_pkg::ST_W_RED: begin
          main_state <= red;
          if (cnt < clsr_pkg::CNT_W'(clsr_pkg::TABLE_DEPTH)) begin
            shuffle_table[cnt[clsr_pkg::SLOT_W-1:0]] <= red;
          end
          if (cnt == '0) begin
            slot <= clsr_pkg::slot_of(red);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        clsr_pkg::ST_A_RED: main_state <= red;
        clsr_pkg::ST_B_RED: second_state <= red;
        clsr_pkg::ST_OUT: begin
          if (out_free) begin
            shuffle_table[slot] <= main_state;
            slot                <= clsr_pkg::slot_of(y);
            m_axis_tdata        <= {1'b0, y};
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("ready while a request is in work");

  a_deviate_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[30:0] != '0) &&
                      (m_axis_tdata[30:0] <= clsr_pkg::TOP_VALUE) &&
                      !m_axis_tdata[31])
    else $error("deviate out of range");

  a_main_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == clsr_pkg::ST_B_MUL) |-> (main_state < clsr_pkg::MOD_A))
    else $error("main state not reduced");

  a_second_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == clsr_pkg::ST_OUT) |-> (second_state < clsr_pkg::MOD_B))
    else $error("second state not reduced");

endmodule
